>>> rtl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and codes for the demand page translator.
// ----------------------------------------------------------------------------
package dpt_pkg;

  typedef enum logic [1:0] {
    KIND_TRANSLATE = 2'd0,
    KIND_ADD_FRAME = 2'd1,
    KIND_FREE_HALF = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_e;

  localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
  localparam logic [10:0] FRAME_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] virtual_addr;
    logic [9:0]  frame_index;
  } in_item_t;

  typedef struct packed {
    logic [21:0] physical_addr;
    logic        newly_mapped;
    logic        fault;
  } out_item_t;

endpackage

>>> rtl/demand_page_translator.sv
// ----------------------------------------------------------------------------
// demand_page_translator
// Virtual-to-physical translation with frame allocation on a page miss.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries one transaction
//   per request: translate, add one frame to the free pool, or free the upper
//   half of the configured frames. Every transaction gives exactly one result
//   on the output channel (out_valid_o/out_ready_i/out_item_o).
//   A translate scans the page map one entry a cycle from a single read
//   port, up to the number of filled map entries; a miss that allocates
//   then does a read-modify-write of one pool word. An add does a
//   read-modify-write of one pool word; a free-half sweeps the 32-frame
//   pool words touched by its range, one read-modify-write per word.
//   One transaction is in work at a time; the next is accepted once the
//   current one has moved its result into the output register.
//   Reset clears the map fill count, the pool word summary and the frame
//   count register (1024); memory contents need no clearing pass.
//   A stalled receiver holds the result in the output register; a new
//   transaction can be accepted and worked on meanwhile, and it waits in
//   the result state until the register frees up.
//   frame_count is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module demand_page_translator
  import dpt_pkg::*;
#(
  parameter int FRAME_SLOTS      = 1024,
  parameter int PAGE_OFFSET_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FW  = $clog2(FRAME_SLOTS);
  localparam int UW  = FW + 1;
  localparam int PW  = 64 - PAGE_OFFSET_BITS;
  localparam int NW  = (FRAME_SLOTS + 31) / 32;
  localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int MW  = PW + FW;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_ALLOC = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_HALF  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  // Lowest set bit of the pool word summary.
  function automatic logic [WW-1:0] low_word(input logic [NW-1:0] v);
    logic [WW-1:0] r;
    r = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (v[i]) r = WW'(i);
    end
    return r;
  endfunction

  function automatic logic [4:0] low_bit(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [10:0] frame_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_FRAME_COUNT) begin
      frame_count_q <= pwdata[10:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_FRAME_COUNT) ? {21'd0, frame_count_q} : 32'd0;

  // --------------------------------------------------------------------------
  // Memories: page map (filled in order) and free pool (32 frames per word)
  // --------------------------------------------------------------------------
  logic [MW-1:0] map_mem [FRAME_SLOTS];
  logic [MW-1:0] map_rd_q;
  logic          map_re, map_we;
  logic [FW-1:0] map_ra, map_wa;
  logic [MW-1:0] map_wd;

  logic [31:0]   pool_mem [NW];
  logic [31:0]   pool_rd_q;
  logic          pool_re, pool_we;
  logic [WW-1:0] pool_ra, pool_wa;
  logic [31:0]   pool_wd;

  always_ff @(posedge clk_i) begin
    if (map_re) map_rd_q <= map_mem[map_ra];
    if (map_we) map_mem[map_wa] <= map_wd;
  end

  always_ff @(posedge clk_i) begin
    if (pool_re) pool_rd_q <= pool_mem[pool_ra];
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  state_e        state_q, state_d;
  logic [UW-1:0] used_q, used_d;      // map entries filled so far
  logic [NW-1:0] summ_q, summ_d;      // pool word holds at least one free frame
  logic [UW-1:0] idx_q, idx_d;        // next map entry to read
  logic          pend_q, pend_d;      // a map read is in flight
  logic [WW-1:0] word_q, word_d;      // pool word under work
  logic [WW-1:0] wlast_q, wlast_d;    // last pool word of a free-half sweep
  logic [16:0]   lo_q, lo_d, hi_q, hi_d;
  in_item_t      item_q;
  out_item_t     res_q, res_d;
  logic          out_valid_q, out_load;
  out_item_t     out_q;

  logic [PW-1:0]               page;
  logic [PAGE_OFFSET_BITS-1:0] offset;
  logic [PW-1:0]               rd_page;
  logic [FW-1:0]               rd_frame;
  logic [31:0]                 cur_word, new_word, mask;
  logic [4:0]                  pick;
  logic [FW-1:0]               new_frame;
  logic [16:0]                 n_clamp, lo_n, hi_n;
  logic                        accept;

  assign page     = item_q.virtual_addr[63:PAGE_OFFSET_BITS];
  assign offset   = item_q.virtual_addr[PAGE_OFFSET_BITS-1:0];
  assign rd_page  = map_rd_q[MW-1:FW];
  assign rd_frame = map_rd_q[FW-1:0];
  assign cur_word = summ_q[word_q] ? pool_rd_q : 32'd0;
  assign pick     = low_bit(cur_word);
  assign new_frame = FW'(32'(word_q) * 32 + 32'(pick));

  assign n_clamp = (32'(frame_count_q) > FRAME_SLOTS) ? 17'(FRAME_SLOTS)
                                                       : 17'(frame_count_q);
  assign lo_n    = n_clamp >> 1;
  assign hi_n    = n_clamp;

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      mask[b] = (32'(word_q) * 32 + b >= 32'(lo_q)) &&
                (32'(word_q) * 32 + b <  32'(hi_q));
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    summ_d   = summ_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    word_d   = word_q;
    wlast_d  = wlast_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    res_d    = res_q;
    map_re   = 1'b0;
    map_we   = 1'b0;
    map_ra   = idx_q[FW-1:0];
    map_wa   = used_q[FW-1:0];
    map_wd   = {page, new_frame};
    pool_re  = 1'b0;
    pool_we  = 1'b0;
    pool_ra  = word_q;
    pool_wa  = word_q;
    pool_wd  = cur_word | mask;
    new_word = cur_word & ~(32'd1 << pick);
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (in_item_i.kind)
            KIND_TRANSLATE: begin
              idx_d   = '0;
              pend_d  = 1'b0;
              state_d = ST_SCAN;
            end
            KIND_ADD_FRAME: begin
              if (32'(in_item_i.frame_index) < FRAME_SLOTS) begin
                word_d  = WW'(in_item_i.frame_index >> 5);
                pool_re = 1'b1;
                pool_ra = WW'(in_item_i.frame_index >> 5);
                state_d = ST_ADD;
              end else begin
                state_d = ST_RESP;
              end
            end
            KIND_FREE_HALF: begin
              if (lo_n < hi_n) begin
                lo_d    = lo_n;
                hi_d    = hi_n;
                word_d  = WW'(lo_n >> 5);
                wlast_d = WW'((hi_n - 17'd1) >> 5);
                pool_re = 1'b1;
                pool_ra = WW'(lo_n >> 5);
                state_d = ST_HALF;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (pend_q && rd_page == page) begin
          // Hit: use the mapped frame.
          res_d.physical_addr = 22'({rd_frame, offset});
          pend_d  = 1'b0;
          state_d = ST_RESP;
        end else if (idx_q < used_q) begin
          map_re = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + UW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // Miss: take the lowest free frame if the map has room.
            if (used_q < UW'(FRAME_SLOTS) && |summ_q) begin
              word_d  = low_word(summ_q);
              pool_re = 1'b1;
              pool_ra = low_word(summ_q);
              state_d = ST_ALLOC;
            end else begin
              res_d.fault = 1'b1;
              state_d     = ST_RESP;
            end
          end
        end
      end
      ST_ALLOC: begin
        pool_we = 1'b1;
        pool_wd = new_word;
        summ_d[word_q] = |new_word;
        map_we  = 1'b1;
        used_d  = used_q + UW'(1);
        res_d.physical_addr = 22'({new_frame, offset});
        res_d.newly_mapped  = 1'b1;
        state_d = ST_RESP;
      end
      ST_ADD: begin
        pool_we = 1'b1;
        pool_wd = cur_word | (32'd1 << item_q.frame_index[4:0]);
        summ_d[word_q] = 1'b1;
        state_d = ST_RESP;
      end
      ST_HALF: begin
        // Merge the range mask into one word, then advance to the next unless it was the last.
        pool_we = 1'b1;
        pool_wd = cur_word | mask;
        summ_d[word_q] = 1'b1;
        if (word_q == wlast_q) begin
          state_d = ST_RESP;
        end else begin
          word_d  = word_q + WW'(1);
          pool_re = 1'b1;
          pool_ra = word_q + WW'(1);
        end
      end
      ST_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      summ_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      summ_q  <= summ_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (out_load) out_q <= res_q;
    word_q  <= word_d;
    wlast_q <= wlast_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives translate, add-frame, free-half and unused transactions into the demand
// page translator under random idling, predicts every result with a behavioral
// page map and free pool, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dpt_pkg::*;

  localparam int NFRAMES  = 1024;
  localparam int OFS_BITS = 12;
  localparam int WATCHDOG = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  demand_page_translator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the translator state.
  logic [10:0] frame_count_q;
  logic        map_valid_q [NFRAMES];
  logic [51:0] map_page_q  [NFRAMES];
  logic [9:0]  map_frame_q [NFRAMES];
  logic        pool_q      [NFRAMES];
  int          map_fill_q;

  out_item_t expected_results[$];
  int  errors;
  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  hold_receiver;
  int  quiet_cycles;

  // Directed rows: item plus an optional typed-in result.
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t result;
  } row_t;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_shadow();
    frame_count_q = FRAME_COUNT_RESET;
    map_fill_q    = 0;
    for (int i = 0; i < NFRAMES; i++) begin
      map_valid_q[i] = 1'b0;
      map_page_q[i]  = '0;
      map_frame_q[i] = '0;
      pool_q[i]      = 1'b0;
    end
  endfunction

  // Apply one transaction to the shadow state and return its result.
  function automatic out_item_t translate_item(in_item_t it);
    out_item_t   r;
    logic [51:0] pg;
    logic [63:0] pa;
    int          frm;
    int          lim;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    frm = -1;
    case (kind_e'(it.kind))
      KIND_TRANSLATE: begin
        pg = it.virtual_addr[63:OFS_BITS];
        for (int i = 0; i < NFRAMES && !hit; i++) begin
          if (map_valid_q[i] && map_page_q[i] == pg) begin
            hit = 1'b1;
            frm = map_frame_q[i];
          end
        end
        if (!hit && map_fill_q < NFRAMES) begin
          for (int i = 0; i < NFRAMES && frm < 0; i++) begin
            if (pool_q[i]) begin
              pool_q[i] = 1'b0;
              frm = i;
            end
          end
          if (frm >= 0) begin
            map_valid_q[map_fill_q] = 1'b1;
            map_page_q[map_fill_q]  = pg;
            map_frame_q[map_fill_q] = frm[9:0];
            map_fill_q++;
            r.newly_mapped = 1'b1;
          end
        end
        if (frm >= 0) begin
          pa = (64'(frm) << OFS_BITS) | 64'(it.virtual_addr[OFS_BITS-1:0]);
          r.physical_addr = pa[21:0];
        end else begin
          r.fault = 1'b1;
        end
      end
      KIND_ADD_FRAME: begin
        if (int'(it.frame_index) < NFRAMES) pool_q[it.frame_index] = 1'b1;
      end
      KIND_FREE_HALF: begin
        lim = (frame_count_q > NFRAMES) ? NFRAMES : int'(frame_count_q);
        for (int i = lim / 2; i < lim; i++) pool_q[i] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // APB write: setup then access; pready is always high.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == REG_FRAME_COUNT) frame_count_q = data[10:0];
  endtask

  // Offer one transaction and hold it until accepted.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk_i);
    in_item_i  = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results = {expected_results, translate_item(it)};
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait for the output side to drain, plus the worst-case scan latency.
  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (map_fill_q + 50) @(negedge clk_i);
  endtask

  function automatic in_item_t mk(kind_e k, logic [63:0] va, logic [9:0] fi);
    in_item_t it;
    it.kind = k; it.virtual_addr = va; it.frame_index = fi;
    return it;
  endfunction

  // Mostly translates over a small page set so hits and misses both occur.
  function automatic in_item_t rand_item();
    logic [63:0] va;
    int          sel;
    sel = $urandom_range(99);
    va  = {$urandom(), $urandom()};
    if ($urandom_range(3) != 0) va[63:OFS_BITS+5] = '0;
    if (sel < 75)      return mk(KIND_TRANSLATE, va, 10'($urandom()));
    else if (sel < 92) return mk(KIND_ADD_FRAME, va, 10'($urandom()));
    else if (sel < 97) return mk(KIND_FREE_HALF, va, 10'($urandom()));
    else               return mk(KIND_UNUSED, va, 10'($urandom()));
  endfunction

  // Receiver: random stall, plus the long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_receiver) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_receiver = 1'b0;
      end
      out_ready_i = ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Compare every accepted result against the oldest prediction.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", out_item_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.physical_addr !== want.physical_addr) begin
            $error("physical_addr expected %h actual %h",
                   want.physical_addr, out_item_o.physical_addr);
            errors++;
          end
          if (out_item_o.newly_mapped !== want.newly_mapped) begin
            $error("newly_mapped expected %b actual %b",
                   want.newly_mapped, out_item_o.newly_mapped);
            errors++;
          end
          if (out_item_o.fault !== want.fault) begin
            $error("fault expected %b actual %b", want.fault, out_item_o.fault);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    int   phase_items;
    errors = 0;
    hold_receiver = 1'b0;
    sender_idle_pct = 0; receiver_idle_pct = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_item_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    reset_shadow();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: empty pool faults, add, hit, sharing, ignored kinds.
    rw.fixed = 1'b1;
    rw.item = mk(KIND_TRANSLATE, '1, 10'd0); rw.result = '{22'd0, 1'b0, 1'b1};
    rows = {rows, rw};
    rw.item = mk(KIND_UNUSED, '1, '1); rw.result = '0; rows = {rows, rw};
    rw.item = mk(KIND_ADD_FRAME, '0, 10'd1023); rw.result = '0; rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    rw.result = '{22'h3FFFFF, 1'b1, 1'b0}; rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'hFFFF_FFFF_FFFF_F000, 10'd0);
    rw.result = '{22'h3FF000, 1'b0, 1'b0}; rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'h0, 10'd0); rw.result = '{22'd0, 1'b0, 1'b1};
    rows = {rows, rw};
    rw.item = mk(KIND_ADD_FRAME, '1, 10'd0); rw.result = '0; rows = {rows, rw};
    rw.item = mk(KIND_ADD_FRAME, '1, 10'd0); rw.result = '0; rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'h0, 10'd0); rw.result = '{22'd0, 1'b1, 1'b0};
    rows = {rows, rw};
    rw.fixed = 1'b0;
    rw.item = mk(KIND_ADD_FRAME, '0, 10'd1023); rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'h5555_AAAA_1234_5ABC, '0); rows = {rows, rw};
    rw.item = mk(KIND_FREE_HALF, '0, '0); rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'hAAAA_5555_0000_0FFF, '0); rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'h0000_0000_0000_1001, '0); rows = {rows, rw};
    rw.item = mk(KIND_TRANSLATE, 64'h5555_AAAA_1234_5000, '0); rows = {rows, rw};
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].fixed && expected_results[$] != rows[i].result) begin
        $error("table row %0d expected %h predicted %h",
               i, rows[i].result, expected_results[$]);
        errors++;
      end
    end
    drain();

    // Random phases over several frame_count settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apb_write(REG_FRAME_COUNT, 32'd0);
        1: apb_write(REG_FRAME_COUNT, 32'd2047);
        2: apb_write(REG_FRAME_COUNT, 32'd1);
        3: apb_write(REG_FRAME_COUNT, 32'd1024);
        4: apb_write(REG_FRAME_COUNT, 32'($urandom_range(2047)));
        default: apb_write(REG_FRAME_COUNT, 32'd64);
      endcase
      if (ph < 2) begin
        sender_idle_pct = 22; receiver_idle_pct = 77;
      end else if (ph < 4) begin
        sender_idle_pct = 77; receiver_idle_pct = 22;
      end else begin
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
      if (ph == 4) hold_receiver = 1'b1;
      phase_items = 305;
      for (int n = 0; n < phase_items; n++) send_item(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
